/* sv/fbpa_pkg.sv */
// ----------------------------------------------------------------------------
// fbpa_pkg
// shared types and constants of the fixed block pool allocator
// ----------------------------------------------------------------------------
package fbpa_pkg;

	localparam int OFFSET_W = 24;
	localparam int COUNT_W  = 9;
	localparam int LOG2_W   = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;
	localparam logic [LOG2_W-1:0]  LOG2_RESET  = 5'd12;
	localparam logic [LOG2_W-1:0]  LOG2_LIMIT  = 5'd16;

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2  = 1'b1;

	typedef enum logic {
		ACT_ALLOC = 1'b0,
		ACT_FREE  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_UNKNOWN = 2'd2
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic start;   // latch request, issue memory reads
		logic commit;  // update state, result valid
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		status_t               status;
		logic [OFFSET_W-1:0]   offset;
	} res_t;

endpackage

/* sv/fbpa_dp.sv */
// ----------------------------------------------------------------------------
// fbpa_dp
// datapath: config registers, free stack memory, allocated map memory
// ----------------------------------------------------------------------------
module fbpa_dp #(
	parameter int MAX_BLOCKS = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fbpa_pkg::COUNT_W-1:0]     cfg_data,
	input  logic                             req_action,
	input  logic [fbpa_pkg::OFFSET_W-1:0]    req_offset,
	input  fbpa_pkg::cmd_t                   cmd,
	output fbpa_pkg::res_t                   res
);

	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [CW-1:0] RST_CNT =
		(256 > MAX_BLOCKS) ? CW'(MAX_BLOCKS) : CW'(256);

	logic [fbpa_pkg::COUNT_W-1:0] count_q, count_nxt;
	logic [fbpa_pkg::LOG2_W-1:0]  log2_q;
	logic [CW-1:0]                eff_cnt, new_eff;
	logic [fbpa_pkg::LOG2_W-1:0]  sh;
	logic [CW-1:0]                fcnt_q;
	logic [CW-1:0]                lw_q;    // lowest stack depth since rebuild

	logic [IW-1:0] stack_mem [MAX_BLOCKS];
	logic          map_mem   [MAX_BLOCKS];

	logic                          action_s1, bad_s1, empty_s1;
	logic [IW-1:0]                 idx_s1, pos_s1, stk_rd_s1;
	logic                          map_rd_s1;

	logic [fbpa_pkg::OFFSET_W-1:0] idx_full;
	logic                          misaligned, out_range;
	logic [IW-1:0]                 pos_addr;
	logic                          p_untouched, b_touched;
	logic [IW-1:0]                 blk;
	logic                          alloc_ok, free_ok;
	logic                          map_we, map_wdata, stk_we;
	logic [IW-1:0]                 map_waddr;

	assign eff_cnt = (32'(count_q) > 32'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(count_q);
	assign count_nxt = (cfg_we && cfg_index == fbpa_pkg::CFG_BLOCK_COUNT) ? cfg_data : count_q;
	assign new_eff = (32'(count_nxt) > 32'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(count_nxt);
	assign sh = (log2_q > fbpa_pkg::LOG2_LIMIT) ? fbpa_pkg::LOG2_LIMIT : log2_q;

	// free request decode
	assign idx_full   = req_offset >> sh;
	assign misaligned = (req_offset & ((24'd1 << sh) - 24'd1)) != '0;
	assign out_range  = 32'(idx_full) >= 32'(eff_cnt);
	assign pos_addr   = IW'(fcnt_q - CW'(1));

	// stack entries below the low-water mark still hold their rebuild value
	assign p_untouched = 32'(pos_s1) < 32'(lw_q);
	assign blk = p_untouched ? IW'(eff_cnt - CW'(1) - CW'(pos_s1)) : stk_rd_s1;
	// blocks above count-lw were never handed out since the rebuild
	assign b_touched = 32'(idx_s1) < 32'(eff_cnt - lw_q);

	assign alloc_ok  = !empty_s1;
	assign free_ok   = !bad_s1 && b_touched && map_rd_s1;
	assign map_we    = cmd.commit && (action_s1 ? free_ok : alloc_ok);
	assign map_waddr = action_s1 ? idx_s1 : blk;
	assign map_wdata = !action_s1;
	assign stk_we    = cmd.commit && action_s1 && free_ok;

	always_comb begin
		res.offset = '0;
		if (action_s1 == fbpa_pkg::ACT_FREE) begin
			res.status = free_ok ? fbpa_pkg::ST_OK : fbpa_pkg::ST_UNKNOWN;
		end else if (alloc_ok) begin
			res.status = fbpa_pkg::ST_OK;
			res.offset = fbpa_pkg::OFFSET_W'(32'(blk) << sh);
		end else begin
			res.status = fbpa_pkg::ST_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= fbpa_pkg::COUNT_RESET;
			log2_q  <= fbpa_pkg::LOG2_RESET;
			fcnt_q  <= RST_CNT;
			lw_q    <= RST_CNT;
		end else if (cfg_we) begin
			count_q <= count_nxt;
			if (cfg_index == fbpa_pkg::CFG_BLOCK_LOG2) begin
				log2_q <= cfg_data[fbpa_pkg::LOG2_W-1:0];
			end
			fcnt_q <= new_eff;
			lw_q   <= new_eff;
		end else if (cmd.commit) begin
			if (action_s1 == fbpa_pkg::ACT_FREE) begin
				if (free_ok) begin
					fcnt_q <= fcnt_q + CW'(1);
				end
			end else if (alloc_ok) begin
				fcnt_q <= fcnt_q - CW'(1);
				if (p_untouched) begin
					lw_q <= CW'(pos_s1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			action_s1 <= req_action;
			idx_s1    <= IW'(idx_full);
			bad_s1    <= misaligned || out_range;
			empty_s1  <= fcnt_q == '0;
			pos_s1    <= pos_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			stk_rd_s1 <= stack_mem[pos_addr];
			map_rd_s1 <= map_mem[IW'(idx_full)];
		end
		if (stk_we) begin
			stack_mem[fcnt_q[IW-1:0]] <= idx_s1;
		end
		if (map_we) begin
			map_mem[map_waddr] <= map_wdata;
		end
	end

endmodule

/* sv/fbpa_ctrl.sv */
// ----------------------------------------------------------------------------
// fbpa_ctrl
// request sequencer and output word register
// ----------------------------------------------------------------------------
module fbpa_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [1:0]                    m_tuser,
	output logic [fbpa_pkg::OFFSET_W-1:0] m_tdata,
	output fbpa_pkg::cmd_t                cmd,
	input  fbpa_pkg::res_t                res
);

	typedef enum logic {
		IDLE,
		EXEC
	} state_t;

	state_t         state_q;
	logic           out_valid_q;
	fbpa_pkg::res_t out_q;
	logic           can_finish;

	assign s_tready   = state_q == IDLE;
	assign can_finish = !out_valid_q || m_tready;
	assign cmd.start  = s_tvalid && s_tready;
	assign cmd.commit = state_q == EXEC && can_finish;

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = out_q.offset;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (cmd.start) begin
						state_q <= EXEC;
					end
				end
				EXEC: begin
					if (can_finish) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
				out_q       <= res;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/fixed_block_pool_allocator.sv */
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// pool of power-of-two sized blocks handed out from a lifo free stack
// ----------------------------------------------------------------------------
// a request reads the memories, then commits into the result word register;
// the next request waits until it commits, set by the read-modify-write of
//   the free stack and allocated map memories (read, then update); a result
//   word held by m_tready low keeps the next request in its read cycle
// reset and config writes rebuild the pool at once through a low-water mark
//   on the free stack, no clearing pass; block 0 is handed out first
module fixed_block_pool_allocator #(
	parameter int MAX_BLOCKS = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request word
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [23:0]                      s_tdata,   // [23:0] offset
	input  logic                             s_tuser,   // [0] action
	// result word
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [23:0]                      m_tdata,   // [23:0] block_offset
	output logic [1:0]                       m_tuser,   // [1:0] status
	// register writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fbpa_pkg::COUNT_W-1:0]     cfg_data
);

	fbpa_pkg::cmd_t cmd;
	fbpa_pkg::res_t res;

	// the user must write only while idle (not enforced); always taken
	assign cfg_ready = 1'b1;

	// sequencer: accepts a word, runs the read cycle, then commits into the
	// output register as soon as it is free
	fbpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.res      (res)
	);

	// stack and map memories, free count, low-water mark, config registers
	fbpa_dp #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req_action (s_tuser),
		.req_offset (s_tdata),
		.cmd        (cmd),
		.res        (res)
	);

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the fixed block pool allocator
// ----------------------------------------------------------------------------
// request words go in on the slave side, and each accepted request is run at
// once through a bench-side copy of the pool: free stack, allocated map and
// both registers. That yields the status and offset that the block must
// return. Each result word is checked in order against the oldest
// prediction. Directed tests cover the reset pool, an empty pool, clamped
// registers and a single-block pool. Random traffic follows, at several pool
// settings, with random idling on both sides except in one calm run.
// ----------------------------------------------------------------------------
module testbench;

	localparam int MAX_BLOCKS   = 256;
	localparam int QUIET_LIMIT  = 4000;  // cycles with no handshake at all
	localparam int SETTLE_TICKS = 8;     // watch for stray result words
	localparam int IDLE_PCT     = 34;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [23:0]                    s_tdata   = '0;   // [23:0] offset
	logic                           s_tuser   = 1'b0; // [0] action
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [23:0]                    m_tdata;          // [23:0] block_offset
	logic [1:0]                     m_tuser;          // [1:0] status
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [fbpa_pkg::COUNT_W-1:0]   cfg_data  = '0;

	// bench copy of the pool
	logic [fbpa_pkg::COUNT_W-1:0] reg_count;
	logic [fbpa_pkg::LOG2_W-1:0]  reg_log2;
	logic [7:0]                   free_stack [MAX_BLOCKS];
	bit                           in_use     [MAX_BLOCKS];
	int                           free_top;

	fbpa_pkg::res_t results_due [$];
	fbpa_pkg::res_t due_word;
	int             fail_count   = 0;
	int             quiet_cycles = 0;
	bit             steady       = 1'b0;  // no idling on either side while set

	fixed_block_pool_allocator #(.MAX_BLOCKS(MAX_BLOCKS)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// pool prediction
	// ------------------------------------------------------------------

	// counts above capacity behave as a full-size pool
	function automatic int pool_size();
		return (reg_count > MAX_BLOCKS) ? MAX_BLOCKS : int'(reg_count);
	endfunction

	// block sizes above 64 KiB are clamped
	function automatic int block_shift();
		return (reg_log2 > fbpa_pkg::LOG2_LIMIT) ? int'(fbpa_pkg::LOG2_LIMIT) : int'(reg_log2);
	endfunction

	// stack top holds block 0, nothing is allocated
	function automatic void pool_rebuild();
		int n;
		n = pool_size();
		for (int k = 0; k < MAX_BLOCKS; k++) begin
			free_stack[k] = (k < n) ? 8'(n - 1 - k) : 8'd0;
			in_use[k]     = 1'b0;
		end
		free_top = n;
	endfunction

	function automatic fbpa_pkg::res_t pool_request(fbpa_pkg::action_t act,
			logic [23:0] off);
		fbpa_pkg::res_t r;
		int             sh;
		int             blk;
		logic [31:0]    idx;
		sh       = block_shift();
		r.status = fbpa_pkg::ST_OK;
		r.offset = '0;
		if (act == fbpa_pkg::ACT_ALLOC) begin
			if (free_top == 0 || free_top > MAX_BLOCKS) begin
				r.status = fbpa_pkg::ST_EMPTY;
			end else begin
				free_top--;
				blk         = free_stack[free_top];
				in_use[blk] = 1'b1;
				r.offset    = 24'(blk << sh);
			end
		end else begin
			idx = {8'd0, off} >> sh;
			// misaligned, past the pool, not held, or stack already full
			if ((idx << sh) != {8'd0, off} || idx >= pool_size() ||
					!in_use[idx[7:0]] || free_top >= MAX_BLOCKS) begin
				r.status = fbpa_pkg::ST_UNKNOWN;
			end else begin
				in_use[idx[7:0]]     = 1'b0;
				free_stack[free_top] = idx[7:0];
				free_top++;
			end
		end
		return r;
	endfunction

	// random currently allocated block, -1 when none is held
	function automatic int pick_in_use();
		int held [$];
		for (int k = 0; k < pool_size(); k++)
			if (in_use[k])
				held.push_back(k);
		if (held.size() == 0)
			return -1;
		return held[$urandom_range(held.size() - 1)];
	endfunction

	// ------------------------------------------------------------------
	// driving
	// ------------------------------------------------------------------

	// entered and left at a falling edge; valid stays high between words
	// unless an idle cycle is taken
	task automatic send_request(fbpa_pkg::action_t act, logic [23:0] off);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= off;
		s_tuser  <= act;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		results_due.push_back(pool_request(act, off));
		@(negedge clk);
	endtask

	task automatic pause_until_drained();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (results_due.size() != 0)
			@(negedge clk);
	endtask

	// registers only change with nothing in flight
	task automatic write_reg(logic [fbpa_pkg::CFG_IDX_W-1:0] idx,
			logic [fbpa_pkg::COUNT_W-1:0] data);
		pause_until_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == fbpa_pkg::CFG_BLOCK_COUNT)
			reg_count = data;
		else
			reg_log2 = data[fbpa_pkg::LOG2_W-1:0];
		pool_rebuild();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// reset pool: 256 blocks of 4 KiB, lifo reuse, rejected frees
	task automatic test_reset_pool();
		send_request(fbpa_pkg::ACT_ALLOC, 24'hFFFFFF);  // offset ignored on allocate
		send_request(fbpa_pkg::ACT_ALLOC, 24'h000000);
		send_request(fbpa_pkg::ACT_FREE,  24'h001000);
		send_request(fbpa_pkg::ACT_FREE,  24'h001000);  // double free
		send_request(fbpa_pkg::ACT_FREE,  24'h000800);  // misaligned
		send_request(fbpa_pkg::ACT_FREE,  24'hFFFFFF);  // past the pool
		send_request(fbpa_pkg::ACT_FREE,  24'h100000);  // block 256, one past the end
		send_request(fbpa_pkg::ACT_FREE,  24'h000000);
		send_request(fbpa_pkg::ACT_ALLOC, 24'h000000);  // block 0 comes back first
	endtask

	// zero count: nothing to hand out, nothing to take back
	task automatic test_empty_pool();
		write_reg(fbpa_pkg::CFG_BLOCK_COUNT, 9'd0);
		send_request(fbpa_pkg::ACT_ALLOC, 24'h000000);
		send_request(fbpa_pkg::ACT_FREE,  24'h000000);
	endtask

	// count and size above their limits are clamped
	task automatic test_clamped_registers();
		write_reg(fbpa_pkg::CFG_BLOCK_COUNT, 9'h1FF);
		write_reg(fbpa_pkg::CFG_BLOCK_LOG2,  9'h1FF);
		send_request(fbpa_pkg::ACT_ALLOC, 24'h000000);
		send_request(fbpa_pkg::ACT_ALLOC, 24'h000000);
		send_request(fbpa_pkg::ACT_FREE,  24'hFF0000);  // last block, never handed out
		send_request(fbpa_pkg::ACT_FREE,  24'h010000);
		send_request(fbpa_pkg::ACT_FREE,  24'h008000);  // misaligned at the clamped size
	endtask

	// one-byte blocks, one block: pool runs dry after a single allocate
	task automatic test_single_block();
		write_reg(fbpa_pkg::CFG_BLOCK_LOG2,  9'd0);
		write_reg(fbpa_pkg::CFG_BLOCK_COUNT, 9'd1);
		send_request(fbpa_pkg::ACT_ALLOC, 24'h000000);
		send_request(fbpa_pkg::ACT_ALLOC, 24'h000000);
		send_request(fbpa_pkg::ACT_FREE,  24'h000001);
		send_request(fbpa_pkg::ACT_FREE,  24'h000000);
		send_request(fbpa_pkg::ACT_FREE,  24'h000000);
	endtask

	// mostly allocates and frees of held blocks, some malformed frees
	task automatic test_random_traffic(int blocks, int lg, int n, bit calm, bit hold_mid);
		int          sh;
		int          roll;
		int          blk;
		logic [23:0] off;
		// upper data bits are junk for the size register
		write_reg(fbpa_pkg::CFG_BLOCK_LOG2,  {4'($urandom), 5'(lg)});
		write_reg(fbpa_pkg::CFG_BLOCK_COUNT, 9'(blocks));
		steady = calm;
		for (int i = 0; i < n; i++) begin
			if (hold_mid && i == n / 2)
				pause_until_drained();
			sh   = block_shift();
			roll = $urandom_range(99);
			off  = 24'($urandom);
			blk  = pick_in_use();
			if (roll < 45 || (roll < 85 && blk < 0))
				send_request(fbpa_pkg::ACT_ALLOC, off);
			else if (roll < 85)
				send_request(fbpa_pkg::ACT_FREE, 24'(blk << sh));
			else if (roll < 90)
				send_request(fbpa_pkg::ACT_FREE, off);
			else if (roll < 94)
				send_request(fbpa_pkg::ACT_FREE,
					24'(($urandom_range(pool_size() - 1) << sh) + 1));
			else if (roll < 97)
				send_request(fbpa_pkg::ACT_FREE, 24'(pool_size() << sh));
			else
				send_request(fbpa_pkg::ACT_FREE,
					24'($urandom_range(pool_size() - 1) << sh));
		end
		steady = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------

	// consumer stalls, none during calm stretches
	always @(negedge clk)
		m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result word: status %0d offset %06h",
						m_tuser, m_tdata);
			end else begin
				due_word = results_due.pop_front();
				if (m_tuser !== due_word.status || m_tdata !== due_word.offset) begin
					fail_count++;
					if (fail_count <= 10)
						$display({"result mismatch: expected status %0d offset %06h,",
							" got status %0d offset %06h"},
							due_word.status, due_word.offset, m_tuser, m_tdata);
				end
			end
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("** fixed_block_pool_allocator: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------

	initial begin
		reg_count = fbpa_pkg::COUNT_RESET;
		reg_log2  = fbpa_pkg::LOG2_RESET;
		pool_rebuild();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_pool();
		test_empty_pool();
		test_clamped_registers();
		test_single_block();

		test_random_traffic(6, 3, 90, 1'b0, 1'b0);
		test_random_traffic($urandom_range(1, 16), $urandom_range(0, 16), 90, 1'b0, 1'b1);
		test_random_traffic(256, 12, 100, 1'b1, 1'b0);
		test_random_traffic(300, 20, 80, 1'b0, 1'b0);
		test_random_traffic($urandom_range(1, 40), 0, 80, 1'b0, 1'b0);
		test_random_traffic(2, 16, 60, 1'b0, 1'b0);

		pause_until_drained();
		repeat (SETTLE_TICKS) @(negedge clk);
		if (fail_count == 0 && results_due.size() == 0)
			$display("** fixed_block_pool_allocator: PASSED **");
		else
			$display("** fixed_block_pool_allocator: FAILED **");
		$finish;
	end

endmodule

/* fixed_block_pool_allocator.f */
sv/fbpa_pkg.sv
sv/fbpa_dp.sv
sv/fbpa_ctrl.sv
sv/fixed_block_pool_allocator.sv
tb/sv/testbench.sv
